// ===== hw/rtl/rwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared widths, state codes and helpers for the running weighted
// two-dimensional mean and covariance accumulator.
// ----------------------------------------------------------------------------
package rwc_pkg;

	// default fraction bits of weights, means and moments
	localparam int FRAC_BITS_DEF = 16;

	// multiply-divide unit operand widths
	localparam int A_W = 64;   // multiplicand and quotient
	localparam int B_W = 49;   // multiplier and divisor (Z + w)

	// wide signed sum for moment updates before saturation
	localparam int SUM_W = 68;

	// moment width
	localparam int MOM_W = 48;

	// multiply-divide unit sequencer states
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	// top-level sequencer states
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_ISSUE,
		SQ_WAIT,
		SQ_WRITE
	} sq_state_t;

	// operations issued to the shared unit, in order
	typedef enum logic [3:0] {
		OP_SDX,
		OP_SDY,
		OP_TVX,
		OP_TVY,
		OP_TCV,
		OP_PX,
		OP_CX,
		OP_PY,
		OP_CY,
		OP_PC,
		OP_CC
	} op_t;

	// control into the multiply-divide unit
	typedef struct packed {
		logic start;
		logic div_en;
	} md_ctrl_t;

	// status out of the multiply-divide unit
	typedef struct packed {
		logic busy;
		logic done;
	} md_stat_t;

	// clamp a wide signed sum to the signed moment range
	function automatic logic signed [MOM_W-1:0] sat_mom(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi_lim;
		logic signed [SUM_W-1:0] lo_lim;
		hi_lim = SUM_W'({1'b0, {(MOM_W-1){1'b1}}});
		lo_lim = -hi_lim - SUM_W'(1);
		if (v > hi_lim) begin
			sat_mom = {1'b0, {(MOM_W-1){1'b1}}};
		end else if (v < lo_lim) begin
			sat_mom = {1'b1, {(MOM_W-1){1'b0}}};
		end else begin
			sat_mom = v[MOM_W-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/rwc_muldiv.sv =====
// ----------------------------------------------------------------------------
// rwc_muldiv
// Shared unit: floor(a*b/d) by a shift-add multiply of one multiplier bit
// per cycle, then a restoring divide of one quotient bit per cycle.
// With the divide skipped it returns the low product bits.
// ----------------------------------------------------------------------------
module rwc_muldiv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rwc_pkg::md_ctrl_t         ctrl,
	input  logic [rwc_pkg::A_W-1:0]   a,
	input  logic [rwc_pkg::B_W-1:0]   b,
	input  logic [rwc_pkg::B_W-1:0]   d,
	output rwc_pkg::md_stat_t         stat,
	output logic [rwc_pkg::A_W-1:0]   result
);
	import rwc_pkg::*;

	localparam int CNT_W = $clog2(A_W);
	localparam int P_W = A_W + 1 + B_W;

	md_state_t st_q, st_d;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0] a_q;
	logic [B_W-1:0] d_q;
	logic div_q;
	logic [A_W:0] hi_q;
	logic [B_W-1:0] lo_q;
	logic [B_W-1:0] rem_q;
	logic [A_W-1:0] quo_q;
	logic done_q;

	logic mul_last;
	logic div_last;
	logic [A_W+1:0] mul_sum;
	logic [P_W-1:0] prod;
	logic [B_W:0] trial;
	logic ge;

	// datapath of one step
	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {2'b00, a_q} : '0);
	assign prod = {hi_q, lo_q};
	assign trial = {rem_q, quo_q[A_W-1]};
	assign ge = trial >= {1'b0, d_q};
	assign mul_last = cnt_q == CNT_W'(B_W - 1);
	assign div_last = cnt_q == CNT_W'(A_W - 1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and status
	always_comb begin
		st_d = st_q;
		stat.busy = st_q != MD_IDLE;
		stat.done = done_q;
		unique case (st_q)
			MD_IDLE: begin
				if (ctrl.start) begin
					st_d = MD_MUL;
				end
			end
			MD_MUL: begin
				if (mul_last) begin
					st_d = div_q ? MD_DIV : MD_IDLE;
				end
			end
			MD_DIV: begin
				if (div_last) begin
					st_d = MD_IDLE;
				end
			end
			default: st_d = MD_IDLE;
		endcase
	end

	// done pulse and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= (st_q == MD_MUL && mul_last && !div_q) || (st_q == MD_DIV && div_last);
			if (st_q == MD_IDLE || (st_q == MD_MUL && mul_last)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		case (st_q)
			MD_IDLE: begin
				if (ctrl.start) begin
					a_q <= a;
					d_q <= d;
					div_q <= ctrl.div_en;
					hi_q <= '0;
					lo_q <= b;
				end
			end
			MD_MUL: begin
				hi_q <= mul_sum[A_W+1:1];
				lo_q <= {mul_sum[0], lo_q[B_W-1:1]};
				if (mul_last) begin
					// product bits above the low A_W seed the remainder
					rem_q <= mul_sum[A_W:A_W+1-B_W];
					quo_q <= {mul_sum[A_W-B_W:0], lo_q[B_W-1:1]};
				end
			end
			MD_DIV: begin
				rem_q <= ge ? B_W'(trial - {1'b0, d_q}) : trial[B_W-1:0];
				quo_q <= {quo_q[A_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign result = div_q ? quo_q : prod[A_W-1:0];

endmodule

// ===== hw/rtl/running_weighted_covariance_2d_core.sv =====
// ----------------------------------------------------------------------------
// running_weighted_covariance_2d_core
// Merges weighted aggregates into running weight, means and moments.
// ----------------------------------------------------------------------------
// Usage
//  Input channel: in_valid / in_stall with weight, means, variances and
//  covariance of one aggregate (a single point has zero moments). A beat is
//  taken only while the core is idle; in_stall stays high during the work.
//  Output channel: out_valid / out_stall, one result beat per input beat with
//  the state after the update and the error flag.
//  Sequence: each input beat runs eleven operations through one shared
//  multiply-divide unit: three plain products (issue, shift-add multiply,
//  done) and eight multiply-divides (which add a restoring divide). The
//  result is registered into the output register, and the next input beat
//  is taken once that write is done. A zero weight skips the unit and goes
//  straight to the write state.
//  Reset clears the running state to zero and drops out_valid.
//  A stalled result is held in the output register; the next input beat is
//  still accepted, and its result waits for that register to be free.
// ----------------------------------------------------------------------------
module running_weighted_covariance_2d_core #(
	parameter int FRAC_BITS = rwc_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        weight,
	input  logic signed [31:0] mean_x_in,
	input  logic signed [31:0] mean_y_in,
	input  logic [46:0]        var_x_in,
	input  logic [46:0]        var_y_in,
	input  logic signed [47:0] cov_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [47:0]        total_weight,
	output logic signed [31:0] mean_x,
	output logic signed [31:0] mean_y,
	output logic signed [47:0] var_x,
	output logic signed [47:0] var_y,
	output logic signed [47:0] cov_xy,
	output logic               error
);
	import rwc_pkg::*;

	// running state
	logic [47:0] acc_w_q;
	logic signed [31:0] acc_mx_q, acc_my_q;
	logic signed [47:0] acc_vx_q, acc_vy_q, acc_cv_q;

	// per-beat operands and partial results
	logic [31:0] w_q;
	logic [48:0] s_q;
	logic err_q;
	logic signed [32:0] dx_q, dy_q, sdx_q, sdy_q;
	logic signed [49:0] dvx_q, dvy_q, dcv_q, tvx_q, tvy_q, tcv_q;
	logic [A_W-1:0] prod_q;
	logic signed [A_W:0] cx_q, cy_q, cc_q;

	// control
	sq_state_t st_q, st_d;
	op_t op_q;
	logic ovalid_q;

	// output registers
	logic [47:0] o_w_q;
	logic signed [31:0] o_mx_q, o_my_q;
	logic signed [47:0] o_vx_q, o_vy_q, o_cv_q;
	logic o_err_q;

	md_ctrl_t md_ctrl;
	md_stat_t md_stat;
	logic [A_W-1:0] md_a, md_res;
	logic [B_W-1:0] md_b;

	logic in_take, commit, op_done;
	logic [32:0] abs_dx, abs_dy, abs_sdx, abs_sdy;
	logic [49:0] abs_dvx, abs_dvy, abs_dcv;
	logic [A_W-1:0] res_shr;
	logic cross_neg;
	logic [A_W:0] cross_val;
	logic signed [SUM_W-1:0] nvx, nvy, ncv;

	assign in_stall = st_q != SQ_IDLE;
	assign in_take = in_valid && !in_stall;
	assign commit = st_q == SQ_WRITE && (!ovalid_q || !out_stall);
	assign op_done = st_q == SQ_WAIT && md_stat.done;

	// magnitudes of signed operands
	assign abs_dx = dx_q[32] ? 33'(-dx_q) : dx_q;
	assign abs_dy = dy_q[32] ? 33'(-dy_q) : dy_q;
	assign abs_sdx = sdx_q[32] ? 33'(-sdx_q) : sdx_q;
	assign abs_sdy = sdy_q[32] ? 33'(-sdy_q) : sdy_q;
	assign abs_dvx = dvx_q[49] ? 50'(-dvx_q) : dvx_q;
	assign abs_dvy = dvy_q[49] ? 50'(-dvy_q) : dvy_q;
	assign abs_dcv = dcv_q[49] ? 50'(-dcv_q) : dcv_q;

	// operand select for the shared unit
	always_comb begin
		md_a = '0;
		md_b = '0;
		md_ctrl.start = st_q == SQ_ISSUE;
		md_ctrl.div_en = 1'b1;
		cross_neg = 1'b0;
		unique case (op_q)
			OP_SDX: begin
				md_a = A_W'(abs_dx);
				md_b = B_W'(w_q);
			end
			OP_SDY: begin
				md_a = A_W'(abs_dy);
				md_b = B_W'(w_q);
			end
			OP_TVX: begin
				md_a = A_W'(abs_dvx);
				md_b = B_W'(w_q);
			end
			OP_TVY: begin
				md_a = A_W'(abs_dvy);
				md_b = B_W'(w_q);
			end
			OP_TCV: begin
				md_a = A_W'(abs_dcv);
				md_b = B_W'(w_q);
			end
			OP_PX: begin
				md_a = A_W'(abs_dx);
				md_b = B_W'(abs_sdx);
				md_ctrl.div_en = 1'b0;
			end
			OP_CX: begin
				md_a = prod_q;
				md_b = B_W'(acc_w_q);
				cross_neg = dx_q[32] ^ sdx_q[32];
			end
			OP_PY: begin
				md_a = A_W'(abs_dy);
				md_b = B_W'(abs_sdy);
				md_ctrl.div_en = 1'b0;
			end
			OP_CY: begin
				md_a = prod_q;
				md_b = B_W'(acc_w_q);
				cross_neg = dy_q[32] ^ sdy_q[32];
			end
			OP_PC: begin
				md_a = A_W'(abs_dx);
				md_b = B_W'(abs_sdy);
				md_ctrl.div_en = 1'b0;
			end
			OP_CC: begin
				md_a = prod_q;
				md_b = B_W'(acc_w_q);
				cross_neg = dx_q[32] ^ sdy_q[32];
			end
			default: ;
		endcase
	end

	rwc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (md_ctrl),
		.a      (md_a),
		.b      (md_b),
		.d      (s_q),
		.stat   (md_stat),
		.result (md_res)
	);

	// signed cross term from the unit quotient
	assign res_shr = md_res >> FRAC_BITS;
	assign cross_val = cross_neg ? (A_W+1)'(-{1'b0, res_shr}) : {1'b0, res_shr};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SQ_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SQ_IDLE: begin
				if (in_take) begin
					st_d = (weight == '0) ? SQ_WRITE : SQ_ISSUE;
				end
			end
			SQ_ISSUE: st_d = SQ_WAIT;
			SQ_WAIT: begin
				if (md_stat.done) begin
					st_d = (op_q == OP_CC) ? SQ_WRITE : SQ_ISSUE;
				end
			end
			SQ_WRITE: begin
				if (!ovalid_q || !out_stall) begin
					st_d = SQ_IDLE;
				end
			end
			default: st_d = SQ_IDLE;
		endcase
	end

	// operation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_SDX;
		end else if (in_take) begin
			op_q <= OP_SDX;
		end else if (op_done && op_q != OP_CC) begin
			op_q <= op_t'(op_q + 4'd1);
		end
	end

	// latch beat operands
	always_ff @(posedge clk) begin
		if (in_take) begin
			w_q <= weight;
			err_q <= weight == '0;
			s_q <= {17'd0, weight} + {1'b0, acc_w_q};
			dx_q <= 33'(mean_x_in) - 33'(acc_mx_q);
			dy_q <= 33'(mean_y_in) - 33'(acc_my_q);
			dvx_q <= $signed({3'b000, var_x_in}) - 50'(acc_vx_q);
			dvy_q <= $signed({3'b000, var_y_in}) - 50'(acc_vy_q);
			dcv_q <= 50'(cov_in) - 50'(acc_cv_q);
		end
	end

	// store unit results
	always_ff @(posedge clk) begin
		if (op_done) begin
			case (op_q)
				OP_SDX: sdx_q <= dx_q[32] ? 33'(-md_res[32:0]) : md_res[32:0];
				OP_SDY: sdy_q <= dy_q[32] ? 33'(-md_res[32:0]) : md_res[32:0];
				OP_TVX: tvx_q <= dvx_q[49] ? 50'(-md_res[49:0]) : md_res[49:0];
				OP_TVY: tvy_q <= dvy_q[49] ? 50'(-md_res[49:0]) : md_res[49:0];
				OP_TCV: tcv_q <= dcv_q[49] ? 50'(-md_res[49:0]) : md_res[49:0];
				OP_PX, OP_PY, OP_PC: prod_q <= md_res;
				OP_CX: cx_q <= cross_val;
				OP_CY: cy_q <= cross_val;
				OP_CC: cc_q <= cross_val;
				default: ;
			endcase
		end
	end

	// moment sums before saturation
	assign nvx = SUM_W'(acc_vx_q) + SUM_W'(tvx_q) + SUM_W'(cx_q);
	assign nvy = SUM_W'(acc_vy_q) + SUM_W'(tvy_q) + SUM_W'(cy_q);
	assign ncv = SUM_W'(acc_cv_q) + SUM_W'(tcv_q) + SUM_W'(cc_q);

	// running state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_w_q <= '0;
			acc_mx_q <= '0;
			acc_my_q <= '0;
			acc_vx_q <= '0;
			acc_vy_q <= '0;
			acc_cv_q <= '0;
		end else if (commit && !err_q) begin
			acc_w_q <= s_q[48] ? '1 : s_q[47:0];
			acc_mx_q <= acc_mx_q + sdx_q[31:0];
			acc_my_q <= acc_my_q + sdy_q[31:0];
			acc_vx_q <= sat_mom(nvx);
			acc_vy_q <= sat_mom(nvy);
			acc_cv_q <= sat_mom(ncv);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (commit) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (commit) begin
			o_err_q <= err_q;
			if (err_q) begin
				o_w_q <= acc_w_q;
				o_mx_q <= acc_mx_q;
				o_my_q <= acc_my_q;
				o_vx_q <= acc_vx_q;
				o_vy_q <= acc_vy_q;
				o_cv_q <= acc_cv_q;
			end else begin
				o_w_q <= s_q[48] ? '1 : s_q[47:0];
				o_mx_q <= acc_mx_q + sdx_q[31:0];
				o_my_q <= acc_my_q + sdy_q[31:0];
				o_vx_q <= sat_mom(nvx);
				o_vy_q <= sat_mom(nvy);
				o_cv_q <= sat_mom(ncv);
			end
		end
	end

	assign out_valid = ovalid_q;
	assign total_weight = o_w_q;
	assign mean_x = o_mx_q;
	assign mean_y = o_my_q;
	assign var_x = o_vx_q;
	assign var_y = o_vy_q;
	assign cov_xy = o_cv_q;
	assign error = o_err_q;

`ifndef SYNTHESIS
	// zero weight skips the shared unit
	a_zero_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && weight == '0) |=> (st_q == SQ_WRITE && err_q))
		else $error("zero weight beat did not go straight to write");

	// unit is only started while idle
	a_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == SQ_ISSUE) |-> !md_stat.busy)
		else $error("shared unit started while busy");

	// total weight never decreases
	a_weight_mono: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (acc_w_q >= $past(acc_w_q)))
		else $error("total weight decreased");

	// rejected beat keeps the state
	a_err_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && err_q) |=> ($stable(acc_mx_q) && $stable(acc_vx_q) && $stable(acc_cv_q)))
		else $error("state changed on zero weight");
`endif

endmodule
